// ----- hdl/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, constants and transfer types of the look-at view matrix
// builder.
// ----------------------------------------------------------------------------
package lav_pkg;

	// Number format
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;

	// Normalizer input: a difference or a raw cross product
	localparam int NIN_W    = FRAC_BITS + 34;
	localparam int POS_W    = $clog2(NIN_W);
	// Largest magnitude is brought to [2^29, 2^30)
	localparam int NORM_MSB = 29;
	localparam int M_W      = NORM_MSB + 1;

	// Square root of the sum of squares
	localparam int SQ_W      = 2 * M_W;
	localparam int SUM_W     = SQ_W + 2;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int SQ_REM_W  = ROOT_W + 3;
	localparam int SQ_STEPS  = 4;
	localparam int SQ_STAGES = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;

	// Divider for the unit components
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int NUM_W     = M_W + FRAC_BITS + 1;
	localparam int DV_REM_W  = ROOT_W + 1;
	localparam int DV_STEPS  = 3;
	localparam int DV_STAGES = (QUO_W + DV_STEPS - 1) / DV_STEPS;

	// Normalizer depth in register stages
	localparam int NRM_LAT = 7 + SQ_STAGES + DV_STAGES;

	// Axis and product widths
	localparam int AX_W  = FRAC_BITS + 2;
	localparam int TU_W  = FRAC_BITS + 3;
	localparam int XP_W  = DATA_W + AX_W;
	localparam int CP_W  = 2 * AX_W;
	localparam int CD_W  = CP_W + 1;
	localparam int DP_W  = TU_W + DATA_W;
	localparam int DOT_W = DP_W + 2;

	// Row codes
	localparam logic [1:0] ROW_LAST = 2'd3;

	typedef logic signed [NIN_W-1:0] nin_t;
	typedef logic signed [AX_W-1:0]  ax_t;
	typedef logic signed [TU_W-1:0]  tu_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] eye_x;
		logic signed [DATA_W-1:0] eye_y;
		logic signed [DATA_W-1:0] eye_z;
		logic signed [DATA_W-1:0] target_x;
		logic signed [DATA_W-1:0] target_y;
		logic signed [DATA_W-1:0] target_z;
		logic signed [DATA_W-1:0] upvec_x;
		logic signed [DATA_W-1:0] upvec_y;
		logic signed [DATA_W-1:0] upvec_z;
	} lav_req_t;

	typedef struct packed {
		logic [1:0]               row_index;
		logic signed [DATA_W-1:0] elem0;
		logic signed [DATA_W-1:0] elem1;
		logic signed [DATA_W-1:0] elem2;
		logic signed [DATA_W-1:0] elem3;
		logic                     last_row;
		logic                     degenerate;
	} lav_rsp_t;

endpackage

// ----- hdl/look_at_view_matrix.sv -----
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Left-handed look-at view matrix builder, signed fixed point, fully
// pipelined, emitting the transposed matrix as four row transfers.
// ----------------------------------------------------------------------------
// Each accepted request (eye, target, up) produces four response transfers,
// rows 0 to 3 in order, the last with last_row set. The datapath is a single
// pipeline of 50 register stages (two vector normalizers of NRM_LAT = 21
// stages each plus cross product, rounding and dot product stages) that takes
// a request in any cycle it advances. The four-row output serializer loads a
// finished item only when idle or as the last row of the previous item is
// taken; req_stall rises while the pipeline holds a finished item the
// serializer cannot yet take. No state survives between requests, and reset
// only clears the valid bits, the busy flag and the row counter.
module look_at_view_matrix
	import lav_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  lav_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output lav_rsp_t rsp
);

	localparam logic signed [CD_W-1:0]   CD_HALF  = CD_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [DOT_W-1:0]  DOT_HALF = DOT_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [DOT_W-1:0]  SAT_HI   = (DOT_W'(1) << (DATA_W - 1)) - DOT_W'(1);
	localparam logic signed [DOT_W-1:0]  SAT_LO   = -SAT_HI - 1;
	localparam logic signed [DATA_W-1:0] ONE_VAL  = DATA_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [2:0][DATA_W-1:0] eye;
		logic signed [2:0][AX_W-1:0]   fw;
		logic                          deg;
	} sideb_t;

	logic adv;
	logic load;
	logic busy_q;
	logic [1:0] row_q;

	// Pipeline valid bits
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [NRM_LAT-1:0]  va_s;
	logic [NRM_LAT-1:0]  vb_s;

	// Global advance: the whole pipeline moves when its tail is free
	assign load      = v_s8 && (!busy_q || (rsp_valid && !rsp_stall && row_q == ROW_LAST));
	assign adv       = !v_s8 || load;
	assign req_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			va_s <= '0;
			vb_s <= '0;
		end else if (adv) begin
			v_s1 <= req_valid;
			va_s <= {va_s[NRM_LAT-2:0], v_s1};
			v_s2 <= va_s[NRM_LAT-1];
			v_s3 <= v_s2;
			vb_s <= {vb_s[NRM_LAT-2:0], v_s3};
			v_s4 <= vb_s[NRM_LAT-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1: input capture
	lav_req_t in_s1;

	always_ff @(posedge clk) begin
		if (adv) in_s1 <= req;
	end

	// Forward direction, normalized
	nin_t da [3];
	ax_t  fw [3];
	logic fw_zero;

	always_comb begin
		da[0] = nin_t'(in_s1.target_x) - nin_t'(in_s1.eye_x);
		da[1] = nin_t'(in_s1.target_y) - nin_t'(in_s1.eye_y);
		da[2] = nin_t'(in_s1.target_z) - nin_t'(in_s1.eye_z);
	end

	lav_norm u_nrm_fw (
		.clk  (clk),
		.en   (adv),
		.vin  (da),
		.vout (fw),
		.zero (fw_zero)
	);

	// Request fields that ride alongside the forward normalizer
	lav_req_t pa_s [NRM_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s[0] <= in_s1;
			for (int k = 1; k < NRM_LAT; k++) pa_s[k] <= pa_s[k-1];
		end
	end

	// Stage 2: up x forward partial products
	logic signed [XP_W-1:0]   xp_s2 [6];
	sideb_t                   sb_s2;
	lav_req_t                 ra;

	assign ra = pa_s[NRM_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s2[0] <= XP_W'(ra.upvec_y) * XP_W'(fw[2]);
			xp_s2[1] <= XP_W'(ra.upvec_z) * XP_W'(fw[1]);
			xp_s2[2] <= XP_W'(ra.upvec_z) * XP_W'(fw[0]);
			xp_s2[3] <= XP_W'(ra.upvec_x) * XP_W'(fw[2]);
			xp_s2[4] <= XP_W'(ra.upvec_x) * XP_W'(fw[1]);
			xp_s2[5] <= XP_W'(ra.upvec_y) * XP_W'(fw[0]);
			sb_s2.eye[0] <= ra.eye_x;
			sb_s2.eye[1] <= ra.eye_y;
			sb_s2.eye[2] <= ra.eye_z;
			for (int i = 0; i < 3; i++) sb_s2.fw[i] <= fw[i];
			sb_s2.deg <= fw_zero;
		end
	end

	// Stage 3: exact cross product
	nin_t   c_s3 [3];
	sideb_t sb_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3[0] <= NIN_W'(xp_s2[0] - xp_s2[1]);
			c_s3[1] <= NIN_W'(xp_s2[2] - xp_s2[3]);
			c_s3[2] <= NIN_W'(xp_s2[4] - xp_s2[5]);
			sb_s3   <= sb_s2;
		end
	end

	// Right direction, normalized
	ax_t  rt [3];
	logic rt_zero;

	lav_norm u_nrm_rt (
		.clk  (clk),
		.en   (adv),
		.vin  (c_s3),
		.vout (rt),
		.zero (rt_zero)
	);

	sideb_t pb_s [NRM_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			pb_s[0] <= sb_s3;
			for (int k = 1; k < NRM_LAT; k++) pb_s[k] <= pb_s[k-1];
		end
	end

	// Stage 4: forward x right partial products
	// (elements of the packed side arrays are unsigned, so signs are restored)
	sideb_t                 rb;
	logic signed [CP_W-1:0] tp_s4 [6];
	ax_t                    rt_s4 [3];
	sideb_t                 sb_s4;

	assign rb = pb_s[NRM_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			tp_s4[0] <= CP_W'($signed(rb.fw[1])) * CP_W'(rt[2]);
			tp_s4[1] <= CP_W'($signed(rb.fw[2])) * CP_W'(rt[1]);
			tp_s4[2] <= CP_W'($signed(rb.fw[2])) * CP_W'(rt[0]);
			tp_s4[3] <= CP_W'($signed(rb.fw[0])) * CP_W'(rt[2]);
			tp_s4[4] <= CP_W'($signed(rb.fw[0])) * CP_W'(rt[1]);
			tp_s4[5] <= CP_W'($signed(rb.fw[1])) * CP_W'(rt[0]);
			rt_s4     <= rt;
			sb_s4.eye <= rb.eye;
			sb_s4.fw  <= rb.fw;
			sb_s4.deg <= rb.deg || rt_zero;
		end
	end

	// Stage 5: true up, rounded half up
	logic signed [CD_W-1:0] cd [3];
	logic signed [CD_W-1:0] cdr [3];
	tu_t                    tu_s5 [3];
	ax_t                    rt_s5 [3];
	sideb_t                 sb_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cd[i]  = CD_W'(tp_s4[2*i]) - CD_W'(tp_s4[2*i+1]) + CD_HALF;
			cdr[i] = cd[i] >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) tu_s5[i] <= cdr[i][TU_W-1:0];
			rt_s5 <= rt_s4;
			sb_s5 <= sb_s4;
		end
	end

	// Stage 6: dot product terms against the eye
	logic signed [DP_W-1:0] dp_s6 [3][3];
	ax_t                    rt_s6 [3];
	tu_t                    tu_s6 [3];
	ax_t                    fw_s6 [3];
	logic                   deg_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dp_s6[0][i] <= DP_W'(rt_s5[i]) * DP_W'($signed(sb_s5.eye[i]));
				dp_s6[1][i] <= DP_W'(tu_s5[i]) * DP_W'($signed(sb_s5.eye[i]));
				dp_s6[2][i] <= DP_W'($signed(sb_s5.fw[i]))
					* DP_W'($signed(sb_s5.eye[i]));
				fw_s6[i]    <= sb_s5.fw[i];
			end
			rt_s6  <= rt_s5;
			tu_s6  <= tu_s5;
			deg_s6 <= sb_s5.deg;
		end
	end

	// Stage 7: negated dots plus rounding half
	logic signed [DOT_W-1:0] nd_s7 [3];
	ax_t                     rt_s7 [3];
	tu_t                     tu_s7 [3];
	ax_t                     fw_s7 [3];
	logic                    deg_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				nd_s7[a] <= DOT_HALF - (DOT_W'(dp_s6[a][0]) + DOT_W'(dp_s6[a][1])
					+ DOT_W'(dp_s6[a][2]));
			end
			rt_s7  <= rt_s6;
			tu_s7  <= tu_s6;
			fw_s7  <= fw_s6;
			deg_s7 <= deg_s6;
		end
	end

	// Stage 8: translation, rounded and saturated
	logic signed [DOT_W-1:0]  ndr [3];
	logic signed [DATA_W-1:0] t_s8 [3];
	ax_t                      rt_s8 [3];
	tu_t                      tu_s8 [3];
	ax_t                      fw_s8 [3];
	logic                     deg_s8;

	always_comb begin
		for (int a = 0; a < 3; a++) ndr[a] = nd_s7[a] >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				if (ndr[a] > SAT_HI)
					t_s8[a] <= SAT_HI[DATA_W-1:0];
				else if (ndr[a] < SAT_LO)
					t_s8[a] <= SAT_LO[DATA_W-1:0];
				else
					t_s8[a] <= ndr[a][DATA_W-1:0];
			end
			rt_s8  <= rt_s7;
			tu_s8  <= tu_s7;
			fw_s8  <= fw_s7;
			deg_s8 <= deg_s7;
		end
	end

	// Row serializer
	logic signed [DATA_W-1:0] t_q [3];
	ax_t                      rt_q [3];
	tu_t                      tu_q [3];
	ax_t                      fw_q [3];
	logic                     deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (rsp_valid && !rsp_stall) begin
			if (row_q == ROW_LAST)
				busy_q <= 1'b0;
			else
				row_q <= 2'(row_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			t_q   <= t_s8;
			rt_q  <= rt_s8;
			tu_q  <= tu_s8;
			fw_q  <= fw_s8;
			deg_q <= deg_s8;
		end
	end

	// Response fields from the held item
	assign rsp_valid = busy_q;

	always_comb begin
		rsp.row_index  = row_q;
		rsp.last_row   = (row_q == ROW_LAST);
		rsp.degenerate = deg_q;
		if (row_q == ROW_LAST) begin
			rsp.elem0 = t_q[0];
			rsp.elem1 = t_q[1];
			rsp.elem2 = t_q[2];
			rsp.elem3 = ONE_VAL;
		end else begin
			rsp.elem0 = DATA_W'(rt_q[row_q]);
			rsp.elem1 = DATA_W'(tu_q[row_q]);
			rsp.elem2 = DATA_W'(fw_q[row_q]);
			rsp.elem3 = '0;
		end
	end

endmodule

// ----- hdl/lav_norm.sv -----
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: magnitude scaling, sum of squares, digit
// serial square root and restoring division, one vector per cycle while en is high.
// ----------------------------------------------------------------------------
module lav_norm
	import lav_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  nin_t vin [3],
	output ax_t  vout [3],
	output logic zero
);

	typedef struct packed {
		logic [2:0][M_W-1:0] m;
		logic [2:0]          neg;
		logic                zero;
	} side_t;

	// Stage 1: magnitudes and signs
	logic [NIN_W-1:0] mag_s1 [3];
	logic [2:0]       neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vin[i][NIN_W-1];
				mag_s1[i] <= vin[i][NIN_W-1] ? (~vin[i] + 1'b1) : vin[i];
			end
		end
	end

	// Stage 2: leading one of the largest magnitude
	logic [NIN_W-1:0] orv;
	logic [POS_W-1:0] pos;
	logic [NIN_W-1:0] mag_s2 [3];
	logic [2:0]       neg_s2;
	logic [POS_W-1:0] pos_s2;
	logic             zero_s2;

	always_comb begin
		orv = mag_s1[0] | mag_s1[1] | mag_s1[2];
		pos = '0;
		for (int b = 0; b < NIN_W; b++) begin
			if (orv[b]) pos = POS_W'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			pos_s2  <= pos;
			zero_s2 <= (orv == '0);
		end
	end

	// Stage 3: common shift of all magnitudes
	logic [NIN_W-1:0] shv [3];
	side_t            sd_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= POS_W'(NORM_MSB))
				shv[i] = mag_s2[i] >> (pos_s2 - POS_W'(NORM_MSB));
			else
				shv[i] = mag_s2[i] << (POS_W'(NORM_MSB) - pos_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sd_s3.m[i] <= shv[i][M_W-1:0];
			sd_s3.neg  <= neg_s2;
			sd_s3.zero <= zero_s2;
		end
	end

	// Stage 4: squares
	logic [SQ_W-1:0] sq_s4 [3];
	side_t           sd_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s4[i] <= SQ_W'(sd_s3.m[i]) * SQ_W'(sd_s3.m[i]);
			sd_s4 <= sd_s3;
		end
	end

	// Stage 5: sum of squares
	logic [SUM_W-1:0] sum_s5;
	side_t            sd_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			sd_s5  <= sd_s4;
		end
	end

	// Square root, two radicand bits per step
	logic [SQ_REM_W-1:0] sqs_rem  [SQ_STAGES+1];
	logic [ROOT_W-1:0]   sqs_root [SQ_STAGES+1];
	logic [SUM_W-1:0]    sqs_rad  [SQ_STAGES+1];
	side_t               sqs_sd   [SQ_STAGES+1];

	always_comb begin
		sqs_rem[0]  = '0;
		sqs_root[0] = '0;
		sqs_rad[0]  = sum_s5;
		sqs_sd[0]   = sd_s5;
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
		logic [SQ_REM_W-1:0] rem_n;
		logic [SQ_REM_W-1:0] trial;
		logic [ROOT_W-1:0]   root_n;
		logic [SUM_W-1:0]    rad_n;

		always_comb begin
			rem_n  = sqs_rem[k];
			root_n = sqs_root[k];
			rad_n  = sqs_rad[k];
			trial  = '0;
			for (int j = 0; j < SQ_STEPS; j++) begin
				if (k * SQ_STEPS + j < ROOT_W) begin
					rem_n = {rem_n[SQ_REM_W-3:0], rad_n[SUM_W-1 -: 2]};
					rad_n = {rad_n[SUM_W-3:0], 2'b00};
					trial = (SQ_REM_W'(root_n) << 2) | SQ_REM_W'(1);
					if (rem_n >= trial) begin
						rem_n  = rem_n - trial;
						root_n = {root_n[ROOT_W-2:0], 1'b1};
					end else begin
						root_n = {root_n[ROOT_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqs_rem[k+1]  <= rem_n;
				sqs_root[k+1] <= root_n;
				sqs_rad[k+1]  <= rad_n;
				sqs_sd[k+1]   <= sqs_sd[k];
			end
		end
	end

	// Divider setup: rounded numerator, upper part as first remainder
	logic [NUM_W-1:0]    num [3];
	logic [DV_REM_W-1:0] dvi_rem_s [3];
	logic [QUO_W-1:0]    dvi_low_s [3];
	logic [ROOT_W-1:0]   dvi_len_s;
	side_t               dvi_sd_s;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = (NUM_W'(sqs_sd[SQ_STAGES].m[i]) << FRAC_BITS)
				+ NUM_W'(sqs_root[SQ_STAGES] >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dvi_rem_s[i] <= DV_REM_W'(num[i] >> QUO_W);
				dvi_low_s[i] <= num[i][QUO_W-1:0];
			end
			dvi_len_s <= sqs_root[SQ_STAGES];
			dvi_sd_s  <= sqs_sd[SQ_STAGES];
		end
	end

	// Restoring division, one quotient bit per step
	logic [DV_REM_W-1:0] dvs_rem [DV_STAGES+1][3];
	logic [QUO_W-1:0]    dvs_low [DV_STAGES+1][3];
	logic [QUO_W-1:0]    dvs_quo [DV_STAGES+1][3];
	logic [ROOT_W-1:0]   dvs_len [DV_STAGES+1];
	side_t               dvs_sd  [DV_STAGES+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dvs_rem[0][i] = dvi_rem_s[i];
			dvs_low[0][i] = dvi_low_s[i];
			dvs_quo[0][i] = '0;
		end
		dvs_len[0] = dvi_len_s;
		dvs_sd[0]  = dvi_sd_s;
	end

	for (genvar k = 0; k < DV_STAGES; k++) begin : g_dv
		logic [DV_REM_W-1:0] rem_n [3];
		logic [QUO_W-1:0]    low_n [3];
		logic [QUO_W-1:0]    quo_n [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_n[i] = dvs_rem[k][i];
				low_n[i] = dvs_low[k][i];
				quo_n[i] = dvs_quo[k][i];
				for (int j = 0; j < DV_STEPS; j++) begin
					if (k * DV_STEPS + j < QUO_W) begin
						rem_n[i] = {rem_n[i][DV_REM_W-2:0], low_n[i][QUO_W-1]};
						low_n[i] = {low_n[i][QUO_W-2:0], 1'b0};
						if (rem_n[i] >= DV_REM_W'(dvs_len[k])) begin
							rem_n[i] = rem_n[i] - DV_REM_W'(dvs_len[k]);
							quo_n[i] = {quo_n[i][QUO_W-2:0], 1'b1};
						end else begin
							quo_n[i] = {quo_n[i][QUO_W-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dvs_rem[k+1][i] <= rem_n[i];
					dvs_low[k+1][i] <= low_n[i];
					dvs_quo[k+1][i] <= quo_n[i];
				end
				dvs_len[k+1] <= dvs_len[k];
				dvs_sd[k+1]  <= dvs_sd[k];
			end
		end
	end

	// Output stage: signs back, zero vector forced to zero
	logic [AX_W-1:0] qe [3];

	always_comb begin
		for (int i = 0; i < 3; i++) qe[i] = AX_W'(dvs_quo[DV_STAGES][i]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dvs_sd[DV_STAGES].zero)
					vout[i] <= '0;
				else if (dvs_sd[DV_STAGES].neg[i])
					vout[i] <= ~qe[i] + 1'b1;
				else
					vout[i] <= qe[i];
			end
			zero <= dvs_sd[DV_STAGES].zero;
		end
	end

endmodule

// ----- hdl/lav_checker.sv -----
// ----------------------------------------------------------------------------
// lav_checker
// Port-level checks of the look-at view matrix builder's row sequence.
// ----------------------------------------------------------------------------
module lav_checker
	import lav_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input lav_rsp_t rsp
);

	// A row that is not the last is followed by the next row of the same item
	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last_row |=>
			rsp_valid && rsp.row_index == 2'($past(rsp.row_index) + 2'd1))
		else $error("row sequence broken");

	// The degenerate flag is the same on every row of an item
	a_deg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last_row |=>
			rsp.degenerate == $past(rsp.degenerate))
		else $error("degenerate flag changed within an item");

	// Last column: zero on axis rows, one on the translation row
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last_row ? rsp.elem3 == (DATA_W'(1) << FRAC_BITS)
			: rsp.elem3 == '0))
		else $error("bad last column");

	// Flag marks the fourth row only
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.last_row == (rsp.row_index == ROW_LAST))
		else $error("last_row flag mismatch");

	// A stalled transfer holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);
